// File: design/look_at_view_matrix_macros.svh
// Assertion macros for the look-at view matrix checker.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication under the block reset.
`define LAVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the block reset.
`define LAVM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lavm_pkg.sv
// Shared constants and types for the look-at view matrix block.
`default_nettype none

package lavm_pkg;

    localparam int FRAC_BITS = 16;
    // unit vector component: magnitude up to 2^FRAC_BITS plus rounding
    localparam int UW   = FRAC_BITS + 3;
    // widest vector fed to the normalizer (up x forward)
    localparam int NW   = FRAC_BITS + 36;
    localparam int MW   = (UW > 33) ? UW : 33;
    localparam int PW   = 2 * MW;
    localparam int DW   = PW + 2;
    localparam int QW   = FRAC_BITS + 3;
    localparam int NUMW = FRAC_BITS + 32;
    localparam int ITW  = $clog2(QW + 1);

    localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;
    localparam logic [1:0] ROW_FIXED = 2'd3;

    typedef struct packed {
        logic [31:0] eye_x;
        logic [31:0] eye_y;
        logic [31:0] eye_z;
        logic [32:0] d_x;
        logic [32:0] d_y;
        logic [32:0] d_z;
        logic [31:0] up_x;
        logic [31:0] up_y;
        logic [31:0] up_z;
    } lavm_item_t;

endpackage

`default_nettype wire

// File: design/look_at_view_matrix.sv
// Look-at view matrix: one camera beat in, four matrix-row beats out.
// Each input beat (eye, target, up; signed Q16.16) yields four output beats, rows 0..3
// (right, up, forward, fixed 0,0,0,1), with tlast on row 3 and tuser set on every row
// when a zero-length vector forced identity rows. A full item occupies the engine
// until its last row is taken into the output stage, output stalls included.
// A degenerate item leaves early, at the first zero-length vector it meets.
// Three normalizations each run a 32-step square root and three 19-step restoring
// divides, and one shared 33x33 multiplier serves the sums of squares, cross products
// and translations. A two-entry queue ahead of the engine takes new beats while it works,
// and a registered output stage holds a row while the engine moves on.
`default_nettype none

module look_at_view_matrix (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  wire logic [287:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // row_index[1:0], col0, col1, col2, col3, zero pad
    output logic [135:0]       m_axis_tdata,
    // degenerate
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);
    import lavm_pkg::*;

    lavm_item_t f_item, q_item;
    logic       f_push, q_full, q_valid, q_pop;
    logic [1:0] o_row;
    logic [31:0] o_c0, o_c1, o_c2, o_c3;

    lavm_front u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .q_full   (q_full),
        .push     (f_push),
        .item     (f_item)
    );

    lavm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (f_item),
        .pop   (q_pop),
        .full  (q_full),
        .valid (q_valid),
        .dout  (q_item)
    );

    lavm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (o_row),
        .out_col0  (o_c0),
        .out_col1  (o_c1),
        .out_col2  (o_c2),
        .out_col3  (o_c3),
        .out_degen (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, o_c3, o_c2, o_c1, o_c0, o_row};

endmodule

`default_nettype wire

// File: design/lavm_front.sv
// Input side: unpacks a camera beat and forms eye minus target.
`default_nettype none

module lavm_front (
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [287:0]            s_tdata,
    input  wire logic                    q_full,
    output logic                         push,
    output lavm_pkg::lavm_item_t         item
);
    import lavm_pkg::*;

    logic signed [31:0] ex, ey, ez, tx, ty, tz;

    assign ex = $signed(s_tdata[31:0]);
    assign ey = $signed(s_tdata[63:32]);
    assign ez = $signed(s_tdata[95:64]);
    assign tx = $signed(s_tdata[127:96]);
    assign ty = $signed(s_tdata[159:128]);
    assign tz = $signed(s_tdata[191:160]);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        item.eye_x = ex;
        item.eye_y = ey;
        item.eye_z = ez;
        item.d_x   = 33'(ex) - 33'(tx);
        item.d_y   = 33'(ey) - 33'(ty);
        item.d_z   = 33'(ez) - 33'(tz);
        item.up_x  = s_tdata[223:192];
        item.up_y  = s_tdata[255:224];
        item.up_z  = s_tdata[287:256];
    end

endmodule

`default_nettype wire

// File: design/lavm_queue.sv
// Two-entry queue between the input side and the matrix engine.
`default_nettype none

module lavm_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire lavm_pkg::lavm_item_t    din,
    input  wire logic                    pop,
    output logic                         full,
    output logic                         valid,
    output lavm_pkg::lavm_item_t         dout
);
    import lavm_pkg::*;

    lavm_item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

// File: design/lavm_back.sv
// Matrix engine: three normalizations, two cross products, translations, row output.
`default_nettype none

module lavm_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire lavm_pkg::lavm_item_t    q_item,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   out_row,
    output logic [31:0]                  out_col0,
    output logic [31:0]                  out_col1,
    output logic [31:0]                  out_col2,
    output logic [31:0]                  out_col3,
    output logic                         out_degen,
    output logic                         out_last
);
    import lavm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ABS   = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIVLD = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_CROSS = 4'd7;
    localparam logic [3:0] S_DOT   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [63:0]        B_INIT = 64'h4000_0000_0000_0000;
    localparam logic signed [DW:0] HALF_T = (DW + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DW:0] T_MAX  = (DW + 1)'(2147483647);
    localparam logic signed [DW:0] T_MIN  = ~T_MAX;

    // control
    logic [3:0]     state_reg;
    logic [1:0]     phase_reg;
    logic [3:0]     cnt_reg;
    logic [1:0]     comp_reg;
    logic [ITW-1:0] it_reg;
    logic [1:0]     row_reg;
    logic           degen_reg;
    logic           out_valid_reg;

    // payload
    logic signed [31:0]   eye_reg [3];
    logic signed [31:0]   up_reg [3];
    logic signed [NW-1:0] vec_reg [3];
    logic [NW-1:0]        mag_reg [3];
    logic [2:0]           neg_reg;
    logic signed [UW-1:0] fw_reg [3];
    logic signed [UW-1:0] rt_reg [3];
    logic signed [UW-1:0] nu_reg [3];
    logic [63:0]          acc_reg;
    logic [63:0]          sq_n_reg;
    logic [63:0]          sq_r_reg;
    logic [63:0]          sq_b_reg;
    logic [31:0]          len_reg;
    logic [31:0]          rem_reg;
    logic [QW-1:0]        nlo_reg;
    logic [QW-1:0]        quo_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] ctmp_reg;
    logic signed [DW-1:0] dot_reg;
    logic [31:0]          tr_reg [3];
    logic [1:0]           out_row_reg;
    logic [31:0]          out_col_reg [4];
    logic                 out_degen_reg;
    logic                 out_last_reg;

    // combinational helpers
    logic [NW-1:0]        abs_mag [3];
    logic                 abs_zero;
    logic [NW-1:0]        or_m;
    logic                 sh_r8, sh_r1, sh_l8, shift_done;
    logic [64:0]          sq_rb;
    logic                 sq_ge;
    logic [NUMW-1:0]      numer;
    logic [32:0]          rem_sh;
    logic                 div_ge;
    logic signed [UW-1:0] uq;
    logic signed [MW-1:0] ca [3];
    logic signed [MW-1:0] cb [3];
    logic signed [MW-1:0] mul_a, mul_b;
    logic [3:0]           isel, csel;
    logic signed [UW-1:0] dot_basis;
    logic signed [DW-1:0] dsum;
    logic signed [DW:0]   tneg, tsh;
    logic [31:0]          tsat;
    logic                 out_load;

    // dot schedule: {row, component} for each of the nine products
    function automatic logic [3:0] dsel(input logic [3:0] c);
        logic [3:0] r;
        case (c)
            4'd0:    r = {ROW_RIGHT, 2'd0};
            4'd1:    r = {ROW_RIGHT, 2'd1};
            4'd2:    r = {ROW_RIGHT, 2'd2};
            4'd3:    r = {ROW_UP, 2'd0};
            4'd4:    r = {ROW_UP, 2'd1};
            4'd5:    r = {ROW_UP, 2'd2};
            4'd6:    r = {ROW_FWD, 2'd0};
            4'd7:    r = {ROW_FWD, 2'd1};
            4'd8:    r = {ROW_FWD, 2'd2};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // cross schedule: product k-1 arrives at count k; odd ones close a component
    function automatic logic csel_cross_odd(input logic [3:0] c);
        logic [3:0] k;
        k = c - 4'd1;
        return k[0];
    endfunction

    function automatic logic [1:0] cross_idx(input logic [3:0] c);
        logic [3:0] k;
        k = c - 4'd1;
        return k[2:1];
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_mag[i] = vec_reg[i][NW-1] ? NW'(-vec_reg[i]) : NW'(vec_reg[i]);
            ca[i] = (phase_reg == 2'd0) ? MW'(up_reg[i]) : MW'(fw_reg[i]);
            cb[i] = (phase_reg == 2'd0) ? MW'(fw_reg[i]) : MW'(rt_reg[i]);
        end
    end

    assign abs_zero = (abs_mag[0] | abs_mag[1] | abs_mag[2]) == '0;

    // leading one of the OR equals leading one of the largest magnitude
    assign or_m       = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign sh_r8      = |or_m[NW-1:39];
    assign sh_r1      = |or_m[NW-1:31];
    assign sh_l8      = ~|or_m[30:22];
    assign shift_done = !sh_r1 && or_m[30];

    assign sq_rb = {1'b0, sq_r_reg} + {1'b0, sq_b_reg};
    assign sq_ge = {1'b0, sq_n_reg} >= sq_rb;

    assign numer  = (NUMW'(mag_reg[comp_reg][30:0]) << FRAC_BITS) + NUMW'(len_reg[31:1]);
    assign rem_sh = {rem_reg, nlo_reg[QW-1]};
    assign div_ge = rem_sh >= {1'b0, len_reg};
    assign uq     = neg_reg[comp_reg] ? -$signed(UW'(quo_reg)) : $signed(UW'(quo_reg));

    assign isel = dsel(cnt_reg);
    assign csel = dsel(cnt_reg - 4'd1);

    always_comb
    begin
        case (isel[3:2])
            ROW_RIGHT: dot_basis = rt_reg[isel[1:0]];
            ROW_UP:    dot_basis = nu_reg[isel[1:0]];
            default:   dot_basis = fw_reg[isel[1:0]];
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                if (cnt_reg < 4'd3)
                begin
                    mul_a = MW'($signed({1'b0, mag_reg[cnt_reg[1:0]][30:0]}));
                    mul_b = mul_a;
                end
            end
            S_CROSS:
            begin
                case (cnt_reg)
                    4'd0:
                    begin
                        mul_a = ca[1];
                        mul_b = cb[2];
                    end
                    4'd1:
                    begin
                        mul_a = ca[2];
                        mul_b = cb[1];
                    end
                    4'd2:
                    begin
                        mul_a = ca[2];
                        mul_b = cb[0];
                    end
                    4'd3:
                    begin
                        mul_a = ca[0];
                        mul_b = cb[2];
                    end
                    4'd4:
                    begin
                        mul_a = ca[0];
                        mul_b = cb[1];
                    end
                    4'd5:
                    begin
                        mul_a = ca[1];
                        mul_b = cb[0];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_DOT:
            begin
                if (cnt_reg < 4'd9)
                begin
                    mul_a = MW'(dot_basis);
                    mul_b = MW'(eye_reg[isel[1:0]]);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // translation: floor((half - dot) / 2^F), then saturate
    assign dsum = ((csel[1:0] == 2'd0) ? DW'(0) : dot_reg) + DW'(prod_reg);
    assign tneg = HALF_T - (DW + 1)'(dsum);
    assign tsh  = tneg >>> FRAC_BITS;
    assign tsat = (tsh > T_MAX) ? 32'h7fff_ffff :
                  (tsh < T_MIN) ? 32'h8000_0000 : tsh[31:0];

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 2'd0;
            cnt_reg       <= 4'd0;
            comp_reg      <= 2'd0;
            it_reg        <= '0;
            row_reg       <= 2'd0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        phase_reg <= 2'd0;
                        state_reg <= S_ABS;
                    end
                end
                S_ABS:
                begin
                    if (abs_zero)
                    begin
                        degen_reg <= 1'b1;
                        row_reg   <= ROW_RIGHT;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (shift_done)
                    begin
                        cnt_reg   <= 4'd0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg == 4'd3)
                    begin
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_SQRT:
                begin
                    if (sq_b_reg == '0)
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= S_DIVLD;
                    end
                end
                S_DIVLD:
                begin
                    it_reg    <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (it_reg == ITW'(QW))
                    begin
                        if (comp_reg == 2'd2)
                        begin
                            cnt_reg   <= 4'd0;
                            state_reg <= (phase_reg == 2'd2) ? S_DOT : S_CROSS;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= S_DIVLD;
                        end
                    end
                    else
                    begin
                        it_reg <= it_reg + ITW'(1);
                    end
                end
                S_CROSS:
                begin
                    if (cnt_reg == 4'd6)
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        state_reg <= S_ABS;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_DOT:
                begin
                    if (cnt_reg == 4'd9)
                    begin
                        degen_reg <= 1'b0;
                        row_reg   <= ROW_RIGHT;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        row_reg <= row_reg + 2'd1;
                        if (row_reg == ROW_FIXED)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    eye_reg[0] <= $signed(q_item.eye_x);
                    eye_reg[1] <= $signed(q_item.eye_y);
                    eye_reg[2] <= $signed(q_item.eye_z);
                    up_reg[0]  <= $signed(q_item.up_x);
                    up_reg[1]  <= $signed(q_item.up_y);
                    up_reg[2]  <= $signed(q_item.up_z);
                    vec_reg[0] <= NW'($signed(q_item.d_x));
                    vec_reg[1] <= NW'($signed(q_item.d_y));
                    vec_reg[2] <= NW'($signed(q_item.d_z));
                end
            end
            S_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= abs_mag[i];
                    neg_reg[i] <= vec_reg[i][NW-1];
                end
            end
            S_SHIFT:
            begin
                // right shifts truncate each magnitude, as a single wide shift would
                for (int i = 0; i < 3; i++)
                begin
                    if (sh_r8)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 8;
                    end
                    else if (sh_r1)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (sh_l8)
                    begin
                        mag_reg[i] <= mag_reg[i] << 8;
                    end
                    else if (!or_m[30])
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_SQ:
            begin
                if (cnt_reg == 4'd0)
                begin
                    acc_reg <= '0;
                end
                else if (cnt_reg == 4'd3)
                begin
                    sq_n_reg <= acc_reg + prod_reg[63:0];
                    sq_r_reg <= '0;
                    sq_b_reg <= B_INIT;
                end
                else
                begin
                    acc_reg <= acc_reg + prod_reg[63:0];
                end
            end
            S_SQRT:
            begin
                if (sq_b_reg == '0)
                begin
                    len_reg <= sq_r_reg[31:0];
                end
                else
                begin
                    if (sq_ge)
                    begin
                        sq_n_reg <= sq_n_reg - sq_rb[63:0];
                        sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_b_reg <= sq_b_reg >> 2;
                end
            end
            S_DIVLD:
            begin
                rem_reg <= 32'(numer[NUMW-1:QW]);
                nlo_reg <= numer[QW-1:0];
                quo_reg <= '0;
            end
            S_DIV:
            begin
                if (it_reg != ITW'(QW))
                begin
                    rem_reg <= div_ge ? 32'(rem_sh - {1'b0, len_reg}) : rem_sh[31:0];
                    nlo_reg <= nlo_reg << 1;
                    quo_reg <= {quo_reg[QW-2:0], div_ge};
                end
                else
                begin
                    case (phase_reg)
                        2'd0:    fw_reg[comp_reg] <= uq;
                        2'd1:    rt_reg[comp_reg] <= uq;
                        default: nu_reg[comp_reg] <= uq;
                    endcase
                end
            end
            S_CROSS:
            begin
                if (cnt_reg != 4'd0)
                begin
                    if (!csel_cross_odd(cnt_reg))
                    begin
                        ctmp_reg <= prod_reg;
                    end
                    else
                    begin
                        vec_reg[cross_idx(cnt_reg)] <= NW'(ctmp_reg - prod_reg);
                    end
                end
            end
            S_DOT:
            begin
                if (cnt_reg != 4'd0)
                begin
                    dot_reg <= dsum;
                    if (csel[1:0] == 2'd2)
                    begin
                        tr_reg[csel[3:2]] <= tsat;
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_row_reg   <= row_reg;
                    out_degen_reg <= degen_reg;
                    out_last_reg  <= row_reg == ROW_FIXED;
                    if (degen_reg)
                    begin
                        for (int c = 0; c < 4; c++)
                        begin
                            out_col_reg[c] <= (2'(c) == row_reg) ? ONE_FX : 32'd0;
                        end
                    end
                    else
                    begin
                        case (row_reg)
                            ROW_RIGHT:
                            begin
                                out_col_reg[0] <= 32'(rt_reg[0]);
                                out_col_reg[1] <= 32'(rt_reg[1]);
                                out_col_reg[2] <= 32'(rt_reg[2]);
                                out_col_reg[3] <= tr_reg[0];
                            end
                            ROW_UP:
                            begin
                                out_col_reg[0] <= 32'(nu_reg[0]);
                                out_col_reg[1] <= 32'(nu_reg[1]);
                                out_col_reg[2] <= 32'(nu_reg[2]);
                                out_col_reg[3] <= tr_reg[1];
                            end
                            ROW_FWD:
                            begin
                                out_col_reg[0] <= 32'(fw_reg[0]);
                                out_col_reg[1] <= 32'(fw_reg[1]);
                                out_col_reg[2] <= 32'(fw_reg[2]);
                                out_col_reg[3] <= tr_reg[2];
                            end
                            default:
                            begin
                                out_col_reg[0] <= 32'd0;
                                out_col_reg[1] <= 32'd0;
                                out_col_reg[2] <= 32'd0;
                                out_col_reg[3] <= ONE_FX;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col0  = out_col_reg[0];
    assign out_col1  = out_col_reg[1];
    assign out_col2  = out_col_reg[2];
    assign out_col3  = out_col_reg[3];
    assign out_degen = out_degen_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// File: design/lavm_checker.sv
// Port-level checks for the look-at view matrix, bound to the top level.
`default_nettype none
`include "look_at_view_matrix_macros.svh"

module lavm_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata,
    input wire logic         m_axis_tuser,
    input wire logic         m_axis_tlast
);
    import lavm_pkg::*;

    `LAVM_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output beat changed")
    `LAVM_ASSERT_NOW(a_last_row, clk, rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[1:0] == ROW_FIXED), "tlast not on fixed row")
    `LAVM_ASSERT_NOW(a_fixed_row, clk, rst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ROW_FIXED), (m_axis_tdata[33:2] == 32'd0) && (m_axis_tdata[65:34] == 32'd0) && (m_axis_tdata[97:66] == 32'd0) && (m_axis_tdata[129:98] == ONE_FX), "fixed row wrong")
    `LAVM_ASSERT_NOW(a_degen_row0, clk, rst_n, m_axis_tvalid && m_axis_tuser && (m_axis_tdata[1:0] == ROW_RIGHT), (m_axis_tdata[33:2] == ONE_FX) && (m_axis_tdata[65:34] == 32'd0) && (m_axis_tdata[97:66] == 32'd0) && (m_axis_tdata[129:98] == 32'd0), "degenerate row 0 not identity")

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: bench/tb_look_at_view_matrix.sv
// Self-checking testbench for the look-at view matrix block.
`timescale 1ns / 100ps
`default_nettype none

module tb_look_at_view_matrix;
    import lavm_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 500;
    localparam int N_RANDOM = 150;

    typedef struct packed {
        logic [1:0]  idx;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic        degen;
        logic        last;
    } mat_row_t;

    // one camera: eye x,y,z, target x,y,z, up x,y,z (index 0 = eye x)
    typedef struct {
        logic [8:0][31:0] v;
        bit               ident;   // rows known to be identity
    } camera_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    mat_row_t rows_pending[$];
    int       errors = 0;
    int       rows_seen = 0;
    int       items_sent = 0;
    int       degen_seen = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       hold_asks = 0;
    int       hold_done = 0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    look_at_view_matrix DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to a unit vector; returns 0 for a zero vector
    function automatic bit unit_vec(input longint v[3], output longint u[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
            return 1'b0;
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + len / 2) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // -dot(r, eye) / 2^FRAC_BITS, half rounds up, then saturated
    function automatic logic [31:0] shift_term(input longint r[3], input longint e[3]);
        longint          t;
        longint          q;
        longint unsigned mag;
        t = -(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
        t = t + (longint'(1) << (FRAC_BITS - 1));
        if (t >= 0)
            q = t >>> FRAC_BITS;
        else
        begin
            mag = longint'(-t);
            mag = (mag + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS;
            q = -longint'(mag);
        end
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic void push_identity();
        rows_pending.push_back('{ROW_RIGHT, ONE_FX, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0});
        rows_pending.push_back('{ROW_UP, 32'd0, ONE_FX, 32'd0, 32'd0, 1'b1, 1'b0});
        rows_pending.push_back('{ROW_FWD, 32'd0, 32'd0, ONE_FX, 32'd0, 1'b1, 1'b0});
        rows_pending.push_back('{ROW_FIXED, 32'd0, 32'd0, 32'd0, ONE_FX, 1'b1, 1'b1});
    endfunction

    function automatic void predict_view(input logic [8:0][31:0] v);
        longint eye[3];
        longint dir[3];
        longint up[3];
        longint fw[3];
        longint rt[3];
        longint nu[3];
        longint tmp[3];
        bit     ok;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(v[i]));
            dir[i] = eye[i] - longint'($signed(v[3 + i]));
            up[i]  = longint'($signed(v[6 + i]));
        end
        ok = unit_vec(dir, fw);
        if (ok)
        begin
            cross3(up, fw, tmp);
            ok = unit_vec(tmp, rt);
        end
        if (ok)
        begin
            cross3(fw, rt, tmp);
            ok = unit_vec(tmp, nu);
        end
        if (!ok)
        begin
            push_identity();
            return;
        end
        rows_pending.push_back('{ROW_RIGHT, rt[0][31:0], rt[1][31:0], rt[2][31:0],
                                 shift_term(rt, eye), 1'b0, 1'b0});
        rows_pending.push_back('{ROW_UP, nu[0][31:0], nu[1][31:0], nu[2][31:0],
                                 shift_term(nu, eye), 1'b0, 1'b0});
        rows_pending.push_back('{ROW_FWD, fw[0][31:0], fw[1][31:0], fw[2][31:0],
                                 shift_term(fw, eye), 1'b0, 1'b0});
        rows_pending.push_back('{ROW_FIXED, 32'd0, 32'd0, 32'd0, ONE_FX, 1'b0, 1'b1});
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: row beat %0d: %s got %h expected %h", $realtime, rows_seen,
                 what, got, want);
        errors++;
    endtask

    // output checker and watchdog
    always @(posedge clk)
    begin
        mat_row_t got;
        mat_row_t want;
        got = '{m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
                m_axis_tdata[97:66], m_axis_tdata[129:98], m_axis_tuser, m_axis_tlast};
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("tb_look_at_view_matrix: done, errors");
            $finish;
        end
        else if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (rows_pending.size() == 0)
            begin
                report_mismatch("unexpected row_index", 32'(got.idx), 32'd0);
            end
            else
            begin
                want = rows_pending.pop_front();
                if (got.idx !== want.idx)
                    report_mismatch("row_index", 32'(got.idx), 32'(want.idx));
                if (got.c0 !== want.c0)
                    report_mismatch("col0", got.c0, want.c0);
                if (got.c1 !== want.c1)
                    report_mismatch("col1", got.c1, want.c1);
                if (got.c2 !== want.c2)
                    report_mismatch("col2", got.c2, want.c2);
                if (got.c3 !== want.c3)
                    report_mismatch("col3", got.c3, want.c3);
                if (got.degen !== want.degen)
                    report_mismatch("degenerate", 32'(got.degen), 32'(want.degen));
                if (got.last !== want.last)
                    report_mismatch("last_row", 32'(got.last), 32'(want.last));
                if (want.degen && want.last)
                    degen_seen++;
            end
            rows_seen++;
        end
    end

    // output side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_asks != hold_done)
        begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_camera(input camera_t cam);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= cam.v;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cam.ident)
            push_identity();
        else
            predict_view(cam.v);
        items_sent++;
    endtask

    function automatic logic [31:0] near_zero();
        return 32'($urandom_range(32'h0020_0000) - 32'h0010_0000);
    endfunction

    function automatic camera_t random_camera();
        camera_t c;
        int      kind;
        logic [31:0] k;
        kind = $urandom_range(9);
        c.ident = 1'b0;
        for (int i = 0; i < 9; i++)
            c.v[i] = (kind < 4) ? $urandom() : near_zero();
        case (kind)
            7: for (int i = 0; i < 3; i++)
                c.v[3 + i] = c.v[i];                    // eye on target
            8: begin                                    // up along view direction
                k = 32'($urandom_range(4) - 2);
                for (int i = 0; i < 3; i++)
                    c.v[6 + i] = 32'(k * (c.v[i] - c.v[3 + i]));
            end
            9: for (int i = 0; i < 3; i++)
                c.v[i] = {$urandom_range(1) ? 2'b01 : 2'b10, 30'($urandom())};
            default: ;
        endcase
        return c;
    endfunction

    localparam logic [31:0] P1 = 32'h0001_0000;
    localparam logic [31:0] M1 = 32'hFFFF_0000;
    localparam logic [31:0] MX = 32'h7FFF_FFFF;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] Z  = 32'h0;

    // directed cameras: {up z,y,x, target z,y,x, eye z,y,x}
    camera_t directed[] = '{
        '{'{Z, P1, Z, Z, Z, Z, 32'h0005_0000, Z, Z}, 1'b0},     // classic camera
        '{'{Z, P1, Z, 32'h1234, 32'h5, 32'h7, 32'h1234, 32'h5, 32'h7}, 1'b1}, // eye=target
        '{'{Z, Z, Z, Z, Z, Z, 32'h0003_0000, Z, Z}, 1'b1},      // zero up
        '{'{P1, Z, Z, Z, Z, Z, 32'h0003_0000, Z, Z}, 1'b1},     // up along forward
        '{'{M1, Z, Z, Z, Z, Z, 32'h0003_0000, Z, Z}, 1'b1},     // up opposite forward
        '{'{Z, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1},                  // all zero
        '{'{Z, P1, Z, Z, Z, Z, MX, MX, MX}, 1'b0},              // negative saturation
        '{'{Z, P1, Z, Z, Z, Z, MN, MN, MN}, 1'b0},              // positive saturation
        '{'{MN, MN, MN, MN, MN, MN, MX, MX, MX}, 1'b0},         // widest difference
        '{'{MX, MX, MX, MX, MX, MX, MN, MN, MN}, 1'b0},
        '{'{MX, MN, MX, MN, MX, MN, MX, MN, MX}, 1'b0},
        '{'{32'hFFFF_FFFF, 32'h1, Z, 32'h1, Z, Z, Z, 32'h1, Z}, 1'b0}, // tiny vectors
        '{'{Z, Z, P1, Z, 32'h0002_0000, Z, Z, Z, Z}, 1'b0},
        '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hAAAA_AAAA}, 1'b0},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Z, Z, Z,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0}
    };

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_camera(directed[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            case (n * 4 / N_RANDOM)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (n == 5)
                hold_asks++;    // output side backs off, input must fill up and stall
            if (n % 40 == 20)
                begin idle_pct = 0; stall_pct = 0; end
            send_camera(random_camera());
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        wait (rows_pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d cameras (%0d identity fallbacks), %0d row beats checked",
                 items_sent, degen_seen, rows_seen);
        $display("idle/stall phases and one long output hold-off exercised");
        if (errors == 0 && rows_pending.size() == 0)
            $display("tb_look_at_view_matrix: done, clean");
        else
            $display("tb_look_at_view_matrix: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
